@@ sv/vt4_pkg.sv @@
// Package for the 4x4 homogeneous vertex transform unit.
// Holds the fixed-point format, the word widths, the operation codes and the shared types.
// No dependencies.
`default_nettype none

package vt4_pkg;

  // Fraction bits of the signed fixed-point coefficient and coordinate format.
  localparam int FRAC_BITS = 16;

  localparam int DATA_W  = 32;
  localparam int NUM_ROW = 4;
  localparam int NUM_COL = 4;
  localparam int NUM_COEF = NUM_ROW * NUM_COL;
  localparam int IDX_W   = $clog2(NUM_COEF);
  localparam int OPD_N   = 3;            // x, y and z operands
  localparam int PROD_W  = 2 * DATA_W;   // full-precision product
  localparam int SUM_W   = PROD_W + 2;   // three products plus translation

  typedef logic signed [DATA_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // The value one in the fixed-point format.
  localparam coef_t COEF_ONE = coef_t'(64'(1) << FRAC_BITS);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_POINT  = 2'd1,
    OP_VECTOR = 2'd2
  } op_e;

endpackage

`default_nettype wire

@@ sv/vt4_matrix.sv @@
// Coefficient store of the vertex transform unit: sixteen registers, identity after reset.
// One coefficient is written per cycle; all sixteen are read in parallel.
// Depends on vt4_pkg.
`default_nettype none

module vt4_matrix (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      wr_en_i,
  input  wire logic [vt4_pkg::IDX_W-1:0] wr_index_i,
  input  wire vt4_pkg::coef_t            wr_value_i,
  output vt4_pkg::coef_t                 coef_o [vt4_pkg::NUM_COEF]
);

  vt4_pkg::coef_t coef_q [vt4_pkg::NUM_COEF];

  // Reset restores the identity: one on the diagonal, zero elsewhere.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vt4_pkg::NUM_COEF; i++) begin
        coef_q[i] <= ((i / vt4_pkg::NUM_COL) == (i % vt4_pkg::NUM_COL)) ?
                     vt4_pkg::COEF_ONE : '0;
      end
    end else if (wr_en_i) begin
      coef_q[wr_index_i] <= wr_value_i;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

@@ sv/vertex_transform_4x4_unit.sv @@
// Top level of the 4x4 homogeneous vertex transform unit.
// Instantiates vt4_matrix and implements the three-stage multiply, sum and saturate pipeline.
// Depends on vt4_pkg and vt4_matrix.
`default_nettype none

// The unit keeps a row-major 4x4 matrix of signed fixed-point coefficients
// (FRAC_BITS fraction bits, Q16.16 by default), which is the identity after
// reset. A load transaction writes one coefficient and produces no result; it
// takes effect for every transform transaction accepted after it. A point
// transaction multiplies the whole matrix by (x, y, z, 1), so the fourth column
// adds translation; a vector transaction uses only the upper 3x3 and returns w
// as zero. Every product is kept at full width, each row is summed exactly,
// shifted right by FRAC_BITS (rounding toward minus infinity) and saturated to
// 32 bits; the saturated flag reports any clamp (w is not counted for vectors).
// Operation code 3 is accepted and ignored. Throughput is one transaction per
// clock, load or transform, with no bubbles between them while the output is
// not stalled. A transform's result reaches the output through three registers:
// the products are registered in the first stage (twelve 32x32 multipliers),
// the row sums in the second, and the shifted and saturated result in the
// output register. Each stage holds its data under backpressure and takes new
// data as soon as it empties or its successor advances, so a stalled output
// does not drop or repeat a result.
module vertex_transform_4x4_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  operation_i,
  input  wire logic [vt4_pkg::IDX_W-1:0]   element_index_i,
  input  wire vt4_pkg::coef_t              element_value_i,
  input  wire vt4_pkg::coef_t              in_x_i,
  input  wire vt4_pkg::coef_t              in_y_i,
  input  wire vt4_pkg::coef_t              in_z_i,

  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output vt4_pkg::coef_t                   out_x_o,
  output vt4_pkg::coef_t                   out_y_o,
  output vt4_pkg::coef_t                   out_z_o,
  output vt4_pkg::coef_t                   out_w_o,
  output logic                             saturated_o
);

  localparam int RowW = vt4_pkg::NUM_ROW - 1;  // index of the w row

  // ---------------------------------------------------------------------------
  // Handshake and stage advance. Each stage accepts when it is empty or when
  // the stage after it is moving on in the same cycle.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic in_fire;
  logic is_load, is_xform, is_point;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o = rdy1;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    is_load  = 1'b0;
    is_xform = 1'b0;
    is_point = 1'b0;
    unique case (vt4_pkg::op_e'(operation_i))
      vt4_pkg::OP_LOAD:   is_load = 1'b1;
      vt4_pkg::OP_POINT: begin
        is_xform = 1'b1;
        is_point = 1'b1;
      end
      vt4_pkg::OP_VECTOR: is_xform = 1'b1;
      default: ;  // unused code: accepted, no effect
    endcase
  end

  // ---------------------------------------------------------------------------
  // Coefficient store. A load is written at its accept edge, so a transform
  // accepted in the next cycle already multiplies with the new value, while a
  // transform accepted earlier has captured its products before the write.
  // ---------------------------------------------------------------------------
  vt4_pkg::coef_t coef [vt4_pkg::NUM_COEF];

  vt4_matrix u_matrix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_fire && is_load),
    .wr_index_i (element_index_i),
    .wr_value_i (element_value_i),
    .coef_o     (coef)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: full-width products, plus the translation column for points.
  // ---------------------------------------------------------------------------
  vt4_pkg::coef_t opd [vt4_pkg::OPD_N];
  vt4_pkg::prod_t prod_d [vt4_pkg::NUM_ROW][vt4_pkg::OPD_N];
  vt4_pkg::prod_t prod_q [vt4_pkg::NUM_ROW][vt4_pkg::OPD_N];
  vt4_pkg::coef_t trans_d [vt4_pkg::NUM_ROW];
  vt4_pkg::coef_t trans_q [vt4_pkg::NUM_ROW];
  logic           point1_q;
  logic           en1;

  assign opd[0] = in_x_i;
  assign opd[1] = in_y_i;
  assign opd[2] = in_z_i;

  always_comb begin
    for (int r = 0; r < vt4_pkg::NUM_ROW; r++) begin
      for (int c = 0; c < vt4_pkg::OPD_N; c++) begin
        prod_d[r][c] = vt4_pkg::prod_t'(coef[vt4_pkg::IDX_W'(r * vt4_pkg::NUM_COL + c)])
                     * vt4_pkg::prod_t'(opd[c]);
      end
      trans_d[r] = is_point ?
                   coef[vt4_pkg::IDX_W'(r * vt4_pkg::NUM_COL + vt4_pkg::OPD_N)] : '0;
    end
  end

  assign en1 = in_fire && is_xform;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q   <= prod_d;
      trans_q  <= trans_d;
      point1_q <= is_point;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: exact row sums. The translation term is aligned to the product
  // scale so that the later shift divides everything by the same power of two.
  // ---------------------------------------------------------------------------
  vt4_pkg::sum_t sum_d [vt4_pkg::NUM_ROW];
  vt4_pkg::sum_t sum_q [vt4_pkg::NUM_ROW];
  logic          point2_q;
  logic          en2;

  always_comb begin
    for (int r = 0; r < vt4_pkg::NUM_ROW; r++) begin
      sum_d[r] = vt4_pkg::sum_t'(prod_q[r][0])
               + vt4_pkg::sum_t'(prod_q[r][1])
               + vt4_pkg::sum_t'(prod_q[r][2])
               + (vt4_pkg::sum_t'(trans_q[r]) <<< vt4_pkg::FRAC_BITS);
    end
  end

  assign en2 = v1_q && rdy2;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sum_q    <= sum_d;
      point2_q <= point1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: arithmetic shift, saturation to 32 bits, and the output register.
  // ---------------------------------------------------------------------------
  vt4_pkg::sum_t  shifted [vt4_pkg::NUM_ROW];
  vt4_pkg::coef_t res_d [vt4_pkg::NUM_ROW];
  logic [vt4_pkg::NUM_ROW-1:0] clamp;
  logic           sat_d;
  vt4_pkg::coef_t res_q [vt4_pkg::NUM_ROW];
  logic           sat_q;
  logic           en3;

  always_comb begin
    for (int r = 0; r < vt4_pkg::NUM_ROW; r++) begin
      shifted[r] = sum_q[r] >>> vt4_pkg::FRAC_BITS;
      // In range when every bit above the result's sign bit matches it.
      clamp[r] = !((&shifted[r][vt4_pkg::SUM_W-1:vt4_pkg::DATA_W-1]) ||
                   !(|shifted[r][vt4_pkg::SUM_W-1:vt4_pkg::DATA_W-1]));
      if (!clamp[r]) begin
        res_d[r] = shifted[r][vt4_pkg::DATA_W-1:0];
      end else if (shifted[r][vt4_pkg::SUM_W-1]) begin
        res_d[r] = {1'b1, {(vt4_pkg::DATA_W-1){1'b0}}};
      end else begin
        res_d[r] = {1'b0, {(vt4_pkg::DATA_W-1){1'b1}}};
      end
    end
    // A vector has no w row: w is zero and cannot saturate.
    if (!point2_q) begin
      res_d[RowW] = '0;
      clamp[RowW] = 1'b0;
    end
    sat_d = |clamp;
  end

  assign en3 = v2_q && rdy3;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits travel with the data.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= en1;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign out_valid_o = v3_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign out_w_o     = res_q[RowW];
  assign saturated_o = sat_q;

endmodule

`default_nettype wire
